[design/smm_pkg.sv]
`timescale 1ns / 1ps

// Shared types and fixed constants of the square matrix multiplier.
package smm_pkg;

   // Element and product widths of the signed Q16.16 arithmetic.
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 64;
   localparam int FRAC_W     = 16;
   // Top bit of the 48-bit range whose right shift by FRAC_W fits in DATA_W.
   localparam int FIT_MSB    = 47;
   localparam int ROW_SIZE_W = 3;

   localparam logic [ROW_SIZE_W-1:0] ROW_SIZE_RESET = 3'd6;
   localparam logic [DATA_W-1:0]     Q_MAX          = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0]     Q_MIN          = 32'h8000_0000;

   // One element pair of A and B.
   typedef struct packed {
      logic signed [DATA_W-1:0] a_element;
      logic signed [DATA_W-1:0] b_element;
   } req_payload_type;

   // One element of the product matrix.
   typedef struct packed {
      logic signed [DATA_W-1:0] product_element;
      logic                     saturated;
      logic                     last;
   } rsp_payload_type;

   // Element of an A row travelling along the cell chain.
   typedef struct packed {
      logic                     valid;
      logic                     first;
      logic                     last;
      logic signed [DATA_W-1:0] a;
   } smm_token_type;

   // Finished dot product held in a cell and shifted out toward cell zero.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     sat;
   } smm_result_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FEED,
      ST_DRAIN,
      ST_UNLOAD
   } smm_state_type;

endpackage

[design/square_matrix_multiply.sv]
`timescale 1ns / 1ps

// Square matrix multiplier, C = A * B, signed Q16.16 elements. The block takes
// n*n element pairs of A and B in row-major order, one per cycle while it
// loads, where n is the row_size register (0 counts as 1, values above
// MAX_ROWS count as MAX_ROWS). A is kept in a RAM; each column of B is kept in
// one cell of a chain of MAX_ROWS multiply-accumulate cells. Each row of A is
// then streamed down the chain, one element per cycle, and every cell forms
// one element of the matching row of C with exact accumulation, a right shift
// by 16 and saturation to 32 bits. The row is shifted out through cell zero,
// one element per cycle while the receiver accepts, before the next row
// starts. Output is row-major; the last element carries last. A row_size
// write is taken only while the block loads, and it discards a partial load.
module square_matrix_multiply
   import smm_pkg::*;
#(
   parameter int MAX_ROWS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ROW_SIZE_W-1:0] csr_data
);

   localparam int IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DEPTH   = MAX_ROWS * MAX_ROWS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   smm_state_type        state_ff;
   smm_state_type        state_in;
   logic [ROW_SIZE_W-1:0] row_size_ff;
   logic [IDX_W-1:0]     last_idx;

   logic [IDX_W-1:0]     ld_row_ff;
   logic [IDX_W-1:0]     ld_col_ff;
   logic [ADDR_W-1:0]    ld_base_ff;
   logic [IDX_W-1:0]     cmp_row_ff;
   logic [ADDR_W-1:0]    cmp_base_ff;
   logic [IDX_W-1:0]     feed_idx_ff;
   logic [IDX_W-1:0]     unl_idx_ff;
   logic                 feed_vld_ff;
   logic                 feed_first_ff;
   logic                 feed_last_ff;
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_ff;

   logic                 req_xfer;
   logic                 csr_xfer;
   logic                 ld_end_col;
   logic                 ld_end;
   logic                 feed_end;
   logic                 unl_end;
   logic                 row_end;
   logic                 unload_go;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [DATA_W-1:0]    ram_rd_data;

   smm_token_type        tok_chain [MAX_ROWS+1];
   smm_result_type       res_chain [MAX_ROWS+1];
   logic [MAX_ROWS-1:0]  fin;

   // Effective row size minus one, clamped to the supported range.
   always_comb begin
      if (row_size_ff == '0) begin
         last_idx = '0;
      end else if (int'(row_size_ff) > MAX_ROWS) begin
         last_idx = IDX_W'(MAX_ROWS - 1);
      end else begin
         last_idx = IDX_W'(row_size_ff - 1'b1);
      end
   end

   assign req_xfer   = req_valid && req_ready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign ld_end_col = (ld_col_ff == last_idx);
   assign ld_end     = ld_end_col && (ld_row_ff == last_idx);
   assign feed_end   = (feed_idx_ff == last_idx);
   assign unl_end    = (unl_idx_ff == last_idx);
   assign row_end    = (cmp_row_ff == last_idx);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_xfer && ld_end) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            if (feed_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (fin[last_idx]) begin
               state_in = ST_UNLOAD;
            end
         end
         ST_UNLOAD: begin
            if (unload_go && unl_end) begin
               state_in = row_end ? ST_LOAD : ST_FEED;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      if (csr_xfer) begin
         state_in = ST_LOAD;
      end
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      unload_go = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
         end
         ST_UNLOAD: begin
            unload_go = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // The row size may change only while no product is being formed.
   assign csr_ready   = (state_ff == ST_LOAD);
   assign ram_we      = req_xfer;
   assign ram_wr_addr = ld_base_ff + ADDR_W'(ld_col_ff);
   assign ram_rd_addr = cmp_base_ff + ADDR_W'(feed_idx_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         row_size_ff   <= ROW_SIZE_RESET;
         ld_row_ff     <= '0;
         ld_col_ff     <= '0;
         ld_base_ff    <= '0;
         cmp_row_ff    <= '0;
         cmp_base_ff   <= '0;
         feed_idx_ff   <= '0;
         unl_idx_ff    <= '0;
         feed_vld_ff   <= 1'b0;
         feed_first_ff <= 1'b0;
         feed_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Load position; a register write restarts the load.
         if (csr_xfer) begin
            row_size_ff <= csr_data;
            ld_row_ff   <= '0;
            ld_col_ff   <= '0;
            ld_base_ff  <= '0;
         end else if (req_xfer) begin
            if (ld_end) begin
               ld_row_ff  <= '0;
               ld_col_ff  <= '0;
               ld_base_ff <= '0;
            end else if (ld_end_col) begin
               ld_row_ff  <= IDX_W'(ld_row_ff + 1'b1);
               ld_col_ff  <= '0;
               ld_base_ff <= ADDR_W'(ld_base_ff + ADDR_W'(MAX_ROWS));
            end else begin
               ld_col_ff  <= IDX_W'(ld_col_ff + 1'b1);
            end
         end

         // Streaming of one A row into the chain.
         feed_vld_ff   <= (state_ff == ST_FEED);
         feed_first_ff <= (feed_idx_ff == '0);
         feed_last_ff  <= feed_end;
         if (state_ff == ST_FEED) begin
            feed_idx_ff <= feed_end ? '0 : IDX_W'(feed_idx_ff + 1'b1);
         end

         // Shift-out of one C row and advance to the next row.
         if (unload_go) begin
            unl_idx_ff <= unl_end ? '0 : IDX_W'(unl_idx_ff + 1'b1);
            if (unl_end) begin
               if (row_end) begin
                  cmp_row_ff  <= '0;
                  cmp_base_ff <= '0;
               end else begin
                  cmp_row_ff  <= IDX_W'(cmp_row_ff + 1'b1);
                  cmp_base_ff <= ADDR_W'(cmp_base_ff + ADDR_W'(MAX_ROWS));
               end
            end
         end

         // Output register valid.
         if (unload_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register payload, taken from cell zero.
   always_ff @(posedge clock) begin
      if (unload_go) begin
         rsp_ff.product_element <= res_chain[0].value;
         rsp_ff.saturated       <= res_chain[0].sat;
         rsp_ff.last            <= unl_end && row_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Left matrix storage.
   smm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.a_element),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Head of the chain: the A element read for this cycle.
   always_comb begin
      tok_chain[0].valid = feed_vld_ff;
      tok_chain[0].first = feed_first_ff;
      tok_chain[0].last  = feed_last_ff;
      tok_chain[0].a     = $signed(ram_rd_data);
   end

   assign res_chain[MAX_ROWS] = '0;

   // Chain of column cells.
   for (genvar c = 0; c < MAX_ROWS; c++) begin : g_cell
      smm_cell #(
         .MAX_ROWS (MAX_ROWS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_in    (tok_chain[c]),
         .tok_out   (tok_chain[c+1]),
         .b_we      (req_xfer && (ld_col_ff == IDX_W'(c))),
         .b_row     (ld_row_ff),
         .b_data    (req_data.b_element),
         .res_shift (unload_go),
         .res_in    (res_chain[c+1]),
         .res_out   (res_chain[c]),
         .fin       (fin[c])
      );
   end

   // The last used column finishes its row only while the chain drains.
   a_fin_in_drain : assert property (@(posedge clock) disable iff (reset)
      fin[last_idx] |-> (state_ff == ST_DRAIN))
      else $error("last column finished outside drain");

   // The load position stays at the origin while the block computes.
   a_load_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (ld_row_ff == '0) && (ld_col_ff == '0))
      else $error("load position moved during computation");

   // Streaming and shift-out never pass the last used column.
   a_feed_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEED) |-> (feed_idx_ff <= last_idx))
      else $error("feed index beyond row size");

   a_unload_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UNLOAD) |-> (unl_idx_ff <= last_idx) && (cmp_row_ff <= last_idx))
      else $error("unload position beyond row size");

   // A transfer into the output register happens only while unloading.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_UNLOAD))
      else $error("output loaded outside unload");

endmodule

[design/smm_ram.sv]
`timescale 1ns / 1ps

// Generic single-port-write, single-port-read RAM with registered read data.
module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 36,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/smm_cell.sv]
`timescale 1ns / 1ps

// One column cell: holds a column of B, multiplies each passing A element by
// the matching B element, accumulates the dot product exactly and keeps the
// rounded result until it is shifted out toward cell zero.
module smm_cell
   import smm_pkg::*;
#(
   parameter int MAX_ROWS = 6,
   localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  smm_token_type       tok_in,
   output smm_token_type       tok_out,
   input  logic                b_we,
   input  logic [IDX_W-1:0]    b_row,
   input  logic [DATA_W-1:0]   b_data,
   input  logic                res_shift,
   input  smm_result_type      res_in,
   output smm_result_type      res_out,
   output logic                fin
);

   localparam int ACC_W = PROD_W + IDX_W + 1;

   smm_token_type            tok_ff;
   logic [IDX_W-1:0]         rd_ff;
   logic [IDX_W-1:0]         idx_sel;
   logic [DATA_W-1:0]        bcol_ff [MAX_ROWS];
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     m_vld_ff;
   logic                     m_first_ff;
   logic                     m_last_ff;
   logic [ACC_W-1:0]         prod_ext;
   logic [ACC_W-1:0]         acc_in;
   logic [ACC_W-1:0]         acc_ff;
   logic                     done_ff;
   logic                     fin_ff;
   smm_result_type           sat_res;
   smm_result_type           res_ff;
   logic [ACC_W-1:FIT_MSB]   acc_top;

   // Column storage of B, written while the matrices load.
   always_ff @(posedge clock) begin
      if (b_we) begin
         bcol_ff[b_row] <= b_data;
      end
   end

   // The first element of a row restarts the row index of this cell.
   assign idx_sel = tok_ff.first ? '0 : rd_ff;
   assign prod_in = $signed(tok_ff.a) * $signed(bcol_ff[idx_sel]);

   // Token stage, handed to the next cell every cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.first <= tok_in.first;
      tok_ff.last  <= tok_in.last;
      tok_ff.a     <= tok_in.a;
      if (tok_ff.valid) begin
         rd_ff <= IDX_W'(idx_sel + 1'b1);
      end
   end

   assign tok_out = tok_ff;

   // Multiply stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= tok_ff.valid;
      end
      m_first_ff <= tok_ff.first;
      m_last_ff  <= tok_ff.last;
      prod_ff    <= prod_in;
   end

   // Exact accumulation of the products.
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = m_first_ff ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         done_ff <= m_vld_ff && m_last_ff;
         fin_ff  <= done_ff;
      end
      if (m_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Shift right by the fraction width and clip to the 32-bit range.
   assign acc_top = acc_ff[ACC_W-1:FIT_MSB];

   always_comb begin
      if ((acc_top == '0) || (acc_top == '1)) begin
         sat_res.value = $signed(acc_ff[FIT_MSB:FRAC_W]);
         sat_res.sat   = 1'b0;
      end else begin
         sat_res.value = acc_ff[ACC_W-1] ? $signed(Q_MIN) : $signed(Q_MAX);
         sat_res.sat   = 1'b1;
      end
   end

   // Result register, loaded at the end of a row and shifted during unload.
   always_ff @(posedge clock) begin
      if (done_ff) begin
         res_ff <= sat_res;
      end else if (res_shift) begin
         res_ff <= res_in;
      end
   end

   assign res_out = res_ff;
   assign fin     = fin_ff;

endmodule

[verif/smm_product_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of the square matrix multiplier. It rebuilds both
// matrices from the element pairs that are transferred in, predicts every
// product element when a load completes, and compares the elements that are
// transferred out, in order, against that prediction.
module smm_product_checker
   import smm_pkg::*;
#(
   parameter int MAX_ROWS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [ROW_SIZE_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam int STORE_DEPTH  = MAX_ROWS * MAX_ROWS;
   // Six Q32.32 products need three guard bits; eight leave room to spare.
   localparam int ACC_W        = PROD_W + 8;
   localparam int REPORT_LIMIT = 10;

   logic signed [DATA_W-1:0] left_copy  [STORE_DEPTH];
   logic signed [DATA_W-1:0] right_copy [STORE_DEPTH];
   logic [ROW_SIZE_W-1:0]    row_size_copy = ROW_SIZE_RESET;
   int                       loaded_pairs  = 0;
   int                       failures      = 0;
   rsp_payload_type          expected_products [$];

   // Row size as the block applies it: zero counts as one, large values clip.
   function automatic int active_rows(logic [ROW_SIZE_W-1:0] code);
      if (code == 0) return 1;
      if (code > MAX_ROWS) return MAX_ROWS;
      return int'(code);
   endfunction

   // One element of C: exact dot product, floor shift by 16, 32-bit clip.
   function automatic rsp_payload_type product_at(int rows, int r, int c);
      logic signed [ACC_W-1:0]  sum;
      logic signed [PROD_W-1:0] term;
      rsp_payload_type          element;
      sum = '0;
      for (int i = 0; i < rows; i++) begin
         term = left_copy[r * rows + i] * right_copy[i * rows + c];
         sum  = sum + term;
      end
      element.last = 1'b0;
      if ((&sum[ACC_W-1:FIT_MSB]) || !(|sum[ACC_W-1:FIT_MSB])) begin
         element.product_element = sum[FIT_MSB:FRAC_W];
         element.saturated       = 1'b0;
      end else begin
         element.product_element = sum[ACC_W-1] ? Q_MIN : Q_MAX;
         element.saturated       = 1'b1;
      end
      return element;
   endfunction

   always @(posedge clock) begin
      int              rows;
      rsp_payload_type want;
      if (reset) begin
         row_size_copy = ROW_SIZE_RESET;
         loaded_pairs  = 0;
         expected_products.delete();
      end else begin
         // A row size write drops any partial load.
         if (csr_valid && csr_ready) begin
            row_size_copy = csr_data;
            loaded_pairs  = 0;
         end

         // Store the pair; the last pair of a load yields the whole product.
         if (req_valid && req_ready) begin
            rows = active_rows(row_size_copy);
            left_copy[loaded_pairs]  = req_data.a_element;
            right_copy[loaded_pairs] = req_data.b_element;
            loaded_pairs++;
            if (loaded_pairs == rows * rows) begin
               loaded_pairs = 0;
               for (int r = 0; r < rows; r++) begin
                  for (int c = 0; c < rows; c++) begin
                     want      = product_at(rows, r, c);
                     want.last = (r == rows - 1) && (c == rows - 1);
                     expected_products.insert(expected_products.size(), want);
                  end
               end
            end
         end

         // Compare each result transfer with the oldest expected element.
         if (rsp_valid && rsp_ready) begin
            if (expected_products.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("unexpected product element %h saturated %b last %b",
                           rsp_data.product_element, rsp_data.saturated, rsp_data.last);
               end
            end else begin
               want = expected_products.pop_front();
               if (rsp_data.product_element !== want.product_element ||
                   rsp_data.saturated !== want.saturated ||
                   rsp_data.last !== want.last) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display({"product element: expected %h sat %b last %b, ",
                               "got %h sat %b last %b"},
                              want.product_element, want.saturated, want.last,
                              rsp_data.product_element, rsp_data.saturated,
                              rsp_data.last);
                  end
               end
            end
         end
      end
      mismatch_count <= failures;
      pending_count  <= expected_products.size();
   end

endmodule

[verif/square_matrix_multiply_test.sv]
`timescale 1ns / 1ps

// Drives element pairs and row size writes into the square matrix multiplier
// and gives the verdict from what the checker reports.
module square_matrix_multiply_test;
   import smm_pkg::*;

   localparam int MAX_ROWS      = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 250;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_PAIRS   = 55;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [ROW_SIZE_W-1:0] csr_data  = '0;

   logic hold_armed    = 1'b0;
   logic hold_done     = 1'b0;
   int   hold_left     = 0;
   int   send_idle_pct = 34;
   int   recv_idle_pct = 67;
   int   stall_cycles  = 0;
   int   mismatch_count;
   int   pending_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   square_matrix_multiply #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   smm_product_checker #(
      .MAX_ROWS (MAX_ROWS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Result receiver: random back-pressure, plus one long hold-off on request.
   always @(posedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: ends the run after too many cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Element mix: extremes, full-range noise, and 25-bit or 20-bit sign-extended values.
   function automatic logic [DATA_W-1:0] pick_element();
      logic [DATA_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(9))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return '0;
         3:       return '1;
         4, 5:    return raw;
         6, 7:    return {{7{raw[24]}}, raw[24:0]};
         default: return {{12{raw[19]}}, raw[19:0]};
      endcase
   endfunction

   // Mostly small matrices, now and then the largest or an out-of-range code.
   function automatic logic [ROW_SIZE_W-1:0] pick_row_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) return ROW_SIZE_W'($urandom_range(1, 0));
      if (roll < 55) return ROW_SIZE_W'($urandom_range(3, 2));
      if (roll < 80) return ROW_SIZE_W'($urandom_range(5, 4));
      return ROW_SIZE_W'($urandom_range(7, 6));
   endfunction

   // One element pair transfer, with a random gap before it.
   task automatic send_pair(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_data.a_element <= a;
      req_data.b_element <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_pairs(int count);
      repeat (count) send_pair(pick_element(), pick_element());
   endtask

   // Row size writes happen only once the block has gone quiet.
   task automatic write_row_size(logic [ROW_SIZE_W-1:0] code);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= code;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Random phase: whole matrices at a random size, sometimes a cut-off load.
   task automatic run_phase(int send_pct, int recv_pct, bit with_hold);
      int                    sent;
      int                    rows;
      logic [ROW_SIZE_W-1:0] code;
      sent          = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < PHASE_PAIRS) begin
         code = (with_hold && sent == 0) ? ROW_SIZE_W'(MAX_ROWS) : pick_row_size();
         write_row_size(code);
         // Fill the block while the receiver holds off.
         if (with_hold && sent == 0) hold_armed <= 1'b1;
         rows = (code == 0) ? 1 : (code > MAX_ROWS) ? MAX_ROWS : int'(code);
         repeat ($urandom_range(3, 1)) begin
            send_random_pairs(rows * rows);
            sent += rows * rows;
         end
         if (rows > 1 && $urandom_range(99) < 20) begin
            send_random_pairs($urandom_range(rows * rows - 1, 1));
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Single-element products: saturation both ways, floor rounding, and
      // the exact edges of the representable range.
      write_row_size(3'd1);
      send_pair(Q_MAX, Q_MAX);
      send_pair(Q_MIN, Q_MIN);
      send_pair(Q_MIN, Q_MAX);
      send_pair(32'hFFFF_FFFF, 32'h0000_0001);
      send_pair(32'h0001_0000, 32'h0001_0000);
      send_pair(32'h0080_0000, 32'h0100_0000);
      send_pair(32'hFF80_0000, 32'h0100_0000);

      // Two-by-two product with mixed signs and zero.
      write_row_size(3'd2);
      send_pair(32'h0002_0000, 32'hFFFF_8000);
      send_pair(32'hFFFE_0000, 32'h0003_0000);
      send_pair(32'h0000_0001, Q_MAX);
      send_pair(32'h0000_0000, Q_MIN);

      // A partial load is thrown away by the write; zero acts as one row.
      send_pair(32'h0001_0000, 32'h0001_0000);
      send_pair(Q_MAX, Q_MIN);
      write_row_size(3'd0);
      send_pair(32'h0001_8000, 32'h0001_8000);

      run_phase(34, 67, 1'b0);
      run_phase(67, 34, 1'b0);
      run_phase(0, 0, 1'b1);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
design/smm_pkg.sv
design/smm_ram.sv
design/smm_cell.sv
design/square_matrix_multiply.sv
verif/smm_product_checker.sv
verif/square_matrix_multiply_test.sv
